// ===== rtl/wavetable_voice_engine_unit_assert.svh =====
// assertion macros for the voice engine checker
`ifndef WAVETABLE_VOICE_ENGINE_UNIT_ASSERT_SVH
`define WAVETABLE_VOICE_ENGINE_UNIT_ASSERT_SVH
// implication checked on every clock, off during reset
`define WVE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WVE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/wve_pkg.sv =====
package wve_pkg;

  localparam int unsigned VoiceBits = 5;

  typedef enum logic [4:0] {
    REG_WAVE_CTRL  = 5'h00,
    REG_PITCH      = 5'h01,
    REG_LSTART_HI  = 5'h02,
    REG_LSTART_LO  = 5'h03,
    REG_LEND_HI    = 5'h04,
    REG_LEND_LO    = 5'h05,
    REG_LVL_RATE   = 5'h06,
    REG_LVL_START  = 5'h07,
    REG_LVL_END    = 5'h08,
    REG_LVL_RAW    = 5'h09,
    REG_POS_HI     = 5'h0A,
    REG_POS_LO     = 5'h0B,
    REG_LVL_CTRL   = 5'h0D,
    REG_LAST_VOICE = 5'h0E,
    REG_CONTROL    = 5'h10,
    REG_BANK       = 5'h11,
    REG_MODE       = 5'h12
  } reg_idx_t;

  localparam logic [1:0] CfgMode   = 2'd0;
  localparam logic [1:0] CfgLast   = 2'd1;
  localparam logic [1:0] CfgFreeze = 2'd2;

  localparam logic [7:0] FlagUlaw   = 8'h01;
  localparam logic [7:0] FlagStop   = 8'h02;
  localparam logic [7:0] FlagByte   = 8'h04;
  localparam logic [7:0] FlagLoop   = 8'h08;
  localparam logic [7:0] FlagBidir  = 8'h10;
  localparam logic [7:0] FlagIrq    = 8'h20;
  localparam logic [7:0] FlagInvert = 8'h40;
  localparam logic [7:0] FlagPend   = 8'h80;
  localparam logic [7:0] LflagDone  = 8'h01;
  localparam logic [7:0] LflagStop  = 8'h02;

  localparam logic [6:0] RampFull = 7'h40;
  localparam logic [7:0] CtrlKeyOn  = 8'h00;
  localparam logic [7:0] CtrlKeyOff = 8'h0F;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture item and read voice
    logic emit;    // compute outputs and start updates
    logic commit;  // write voice back
  } wve_cmd_t;

  typedef struct packed {
    logic is_write;
  } wve_status_t;

  // volume table: 8-bit mantissa, 4-bit exponent
  function automatic logic [15:0] vol_table(input logic [11:0] i);
    logic [22:0] m;
    m = {8'd0, 1'b1, i[7:0], 6'd0};
    vol_table = 16'(m >> (4'd15 - i[11:8]));
  endfunction

  function automatic logic is_pos(input logic [31:0] x);
    is_pos = (x != 32'd0) && !x[31];
  endfunction

endpackage

// ===== rtl/wve_ctrl.sv =====
module wve_ctrl
  import wve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  wve_status_t status,
  output wve_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT, S_WRITE} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (start) state_r <= S_READ;
        S_READ:  state_r <= status.is_write ? S_WRITE : S_EMIT;
        S_EMIT:  state_r <= S_WRITE;
        S_WRITE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && start;
  assign cmd.emit    = (state_r == S_EMIT);
  assign cmd.commit  = (state_r == S_WRITE);

endmodule

// ===== rtl/wve_datapath.sv =====
module wve_datapath
  import wve_pkg::*;
#(
  parameter int unsigned VOICE_COUNT   = 32,
  parameter int unsigned ROM_ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  wve_cmd_t    cmd,
  output wve_status_t status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_op,
  input  logic [4:0]  in_voice_index,
  input  logic [4:0]  in_reg_index,
  input  logic        in_high_byte,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  output logic [23:0] out_fetch_address,
  output logic [23:0] out_next_address,
  output logic [8:0]  out_fraction,
  output logic        out_ulaw_format,
  output logic        out_byte_format,
  output logic [14:0] out_gain,
  output logic        out_audible,
  output logic        out_wave_irq,
  output logic        out_envelope_irq
);

  localparam int unsigned VB = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [31:0] AMask = 32'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  // per-voice state, small enough for flops with reset
  logic [31:0] wpos_r [VOICE_COUNT];
  logic [31:0] wrem_r [VOICE_COUNT];
  logic [31:0] lst_r  [VOICE_COUNT];
  logic [31:0] lend_r [VOICE_COUNT];
  logic [15:0] pstep_r[VOICE_COUNT];
  logic [7:0]  bank_r [VOICE_COUNT];
  logic [7:0]  wflg_r [VOICE_COUNT];
  logic [31:0] lpos_r [VOICE_COUNT];
  logic [31:0] lsta_r [VOICE_COUNT];
  logic [31:0] lendv_r[VOICE_COUNT];
  logic [7:0]  lrate_r[VOICE_COUNT];
  logic [15:0] lraw_r [VOICE_COUNT];
  logic [7:0]  lflg_r [VOICE_COUNT];
  logic [7:0]  ctl_r  [VOICE_COUNT];
  logic        key_r  [VOICE_COUNT];
  logic [6:0]  ramp_r [VOICE_COUNT];

  logic [7:0] mode_r;
  logic [4:0] last_r;
  logic       frz_r;

  // working copy of one voice
  logic [VB-1:0] v_r;
  logic        op_r, hi_r;
  logic [4:0]  ri_r;
  logic [7:0]  d_r;
  logic [31:0] wpos_c, wrem_c, lst_c, lend_c, lpos_c, lsta_c, lendv_c;
  logic [15:0] pstep_c, lraw_c;
  logic [7:0]  bank_c, wflg_c, lrate_c, lflg_c, ctl_c;
  logic        key_c;
  logic [6:0]  ramp_c;
  logic [15:0] volt_r;

  // voice index reduction: restoring compare-subtract over narrow values
  logic [4:0] vmod;
  logic [5:0] lp1;
  logic [VB-1:0] vsel;
  always_comb begin
    logic [10:0] t;
    lp1 = {1'b0, last_r} + 6'd1;
    t = {6'd0, in_voice_index};
    for (int k = 0; k < 5; k++) begin
      if (t >= ({5'd0, lp1} << (4 - k))) t = t - ({5'd0, lp1} << (4 - k));
    end
    vmod = t[4:0];
    t = {6'd0, vmod};
    for (int k = 0; k < 5; k++) begin
      if (t >= (11'(VOICE_COUNT) << (4 - k))) t = t - (11'(VOICE_COUNT) << (4 - k));
    end
    vsel = VB'(t);
  end

  assign status.is_write = op_r;

  // tick computation on working copy
  logic        play0, aud;
  logic [31:0] base, cur, nxt, step;
  logic [6:0]  ramp_n;
  logic [31:0] wpos_n, wrem_n, lpos_n;
  logic [7:0]  wflg_n, lflg_n;
  logic        key_n, wirq, eirq;
  logic [22:0] gainp;

  always_comb begin
    logic play1, envoff;
    logic [31:0] add, left;
    add   = 32'd0;
    left  = 32'd0;
    base  = ({24'd0, bank_c} << 20) & AMask;
    cur   = (base | (wpos_c >> 12)) & AMask;
    step  = {14'd0, pstep_c, 2'b00};
    envoff = (lflg_c[1:0] != 2'b00);
    play0 = key_c && !(envoff && wflg_c[1]);
    if (key_c && (wflg_c & FlagLoop) != 0 && (wflg_c & FlagBidir) == 0 &&
        (wrem_c[31] || wrem_c < step))
      nxt = (base | (lst_c >> 12)) & AMask;
    else
      nxt = (cur + 32'd2) & AMask;
    aud = (mode_r == 8'd0) || play0;
    gainp = 23'(volt_r * ramp_c) >> 6;

    if (key_c && (wflg_c & FlagStop) == 0)
      ramp_n = (ramp_c < RampFull) ? ramp_c + 7'd1 : RampFull;
    else
      ramp_n = (ramp_c != 7'd0) ? ramp_c - 7'd1 : 7'd0;

    wpos_n = wpos_c; wrem_n = wrem_c; wflg_n = wflg_c;
    lpos_n = lpos_c; lflg_n = lflg_c; key_n = key_c;
    wirq = 1'b0; eirq = 1'b0;
    play1 = play0;
    if (play1 && (wflg_n & FlagStop) == 0) begin
      if ((wflg_n & FlagInvert) != 0) begin
        wpos_n = wpos_n - step; wrem_n = wpos_n - lst_c;
      end else begin
        wpos_n = wpos_n + step; wrem_n = lend_c - wpos_n;
      end
      if (!is_pos(wrem_n)) begin
        if ((wflg_n & FlagIrq) != 0) begin
          wflg_n = wflg_n | FlagPend; wirq = 1'b1;
        end
        if ((wflg_n & FlagLoop) != 0) begin
          if ((wflg_n & FlagBidir) != 0) wflg_n = wflg_n ^ FlagInvert;
          if ((wflg_n & FlagInvert) != 0) begin
            wpos_n = lend_c + wrem_n; wrem_n = wpos_n - lst_c;
          end else begin
            wpos_n = lst_c - wrem_n; wrem_n = lend_c - wpos_n;
          end
        end else begin
          key_n = 1'b0;
          wflg_n = wflg_n | FlagStop;
          wpos_n = ((wflg_n & FlagInvert) != 0) ? lst_c : lend_c;
        end
      end
    end
    if (play1 && !frz_r && lflg_n[1:0] == 2'b00) begin
      unique case (lrate_c[7:6])
        2'd0:    add = {17'd0, lrate_c[5:0], 9'd0};
        2'd1:    add = {24'd0, lrate_c[5:0], 2'd0};
        default: add = 32'd0;
      endcase
      if ((lflg_n & FlagInvert) != 0) begin
        lpos_n = lpos_n - add; left = lpos_n - lsta_c;
      end else begin
        lpos_n = lpos_n + add; left = lendv_c - lpos_n;
      end
      if (!is_pos(left)) begin
        if ((lflg_n & FlagIrq) != 0) begin
          lflg_n = lflg_n | FlagPend; eirq = 1'b1;
        end
        if ((wflg_n & FlagByte) == 0) begin
          if ((lflg_n & FlagLoop) != 0) begin
            if ((lflg_n & FlagBidir) != 0) lflg_n = lflg_n ^ FlagInvert;
            if ((lflg_n & FlagInvert) != 0) lpos_n = lendv_c + left;
            else lpos_n = lsta_c - left;
          end else begin
            key_n = 1'b0;
            lflg_n = lflg_n | LflagDone;
            lpos_n = ((lflg_n & FlagInvert) != 0) ? lendv_c : lsta_c;
          end
        end
      end
    end
  end

  // load, emit and write-side capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= vsel; op_r <= in_op; ri_r <= in_reg_index;
      hi_r <= in_high_byte; d_r <= in_data_byte;
      wpos_c <= wpos_r[vsel]; wrem_c <= wrem_r[vsel]; lst_c <= lst_r[vsel];
      lend_c <= lend_r[vsel]; pstep_c <= pstep_r[vsel]; bank_c <= bank_r[vsel];
      wflg_c <= wflg_r[vsel]; lpos_c <= lpos_r[vsel]; lsta_c <= lsta_r[vsel];
      lendv_c <= lendv_r[vsel]; lrate_c <= lrate_r[vsel]; lraw_c <= lraw_r[vsel];
      lflg_c <= lflg_r[vsel]; ctl_c <= ctl_r[vsel]; key_c <= key_r[vsel];
      ramp_c <= ramp_r[vsel];
      volt_r <= vol_table(lpos_r[vsel][25:14]);
    end else if (cmd.emit) begin
      out_fetch_address <= cur[23:0];
      out_next_address  <= nxt[23:0];
      out_fraction      <= wpos_c[11:3];
      out_ulaw_format   <= wflg_c[0];
      out_byte_format   <= wflg_c[2];
      out_gain          <= gainp[14:0];
      out_audible       <= aud;
      out_wave_irq      <= wirq;
      out_envelope_irq  <= eirq;
      ramp_c <= ramp_n; wpos_c <= wpos_n; wrem_c <= wrem_n;
      wflg_c <= wflg_n; lpos_c <= lpos_n; lflg_c <= lflg_n; key_c <= key_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
  end

  // register write result applied to the voice table at commit
  logic        wr;
  reg_idx_t    ri;
  always_comb begin
    wr = op_r;
    ri = reg_idx_t'(ri_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        wpos_r[i] <= '0; wrem_r[i] <= '0; lst_r[i] <= '0; lend_r[i] <= '0;
        pstep_r[i] <= '0; bank_r[i] <= '0; wflg_r[i] <= FlagStop;
        lpos_r[i] <= '0; lsta_r[i] <= '0; lendv_r[i] <= '0; lrate_r[i] <= '0;
        lraw_r[i] <= '0; lflg_r[i] <= LflagDone; ctl_r[i] <= '0;
        key_r[i] <= 1'b0; ramp_r[i] <= '0;
      end
      mode_r <= '0; last_r <= 5'd31; frz_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgMode:   mode_r <= cfg_data;
          CfgLast:   last_r <= cfg_data[4:0];
          CfgFreeze: frz_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.commit && !wr) begin
        wpos_r[v_r] <= wpos_c; wrem_r[v_r] <= wrem_c; wflg_r[v_r] <= wflg_c;
        lpos_r[v_r] <= lpos_c; lflg_r[v_r] <= lflg_c; key_r[v_r] <= key_c;
        ramp_r[v_r] <= ramp_c;
      end
      if (cmd.commit && wr) begin
        case (ri)
          REG_WAVE_CTRL: if (hi_r) wflg_r[v_r] <= {wflg_c[7], d_r[6:0]};
          REG_PITCH:
            if (hi_r) pstep_r[v_r] <= {d_r, pstep_c[7:0]};
            else pstep_r[v_r] <= {pstep_c[15:8], d_r & 8'hFE};
          REG_LSTART_HI:
            if (hi_r) lst_r[v_r] <= {d_r, lst_c[23:0]};
            else lst_r[v_r] <= {lst_c[31:24], d_r, lst_c[15:0]};
          REG_LSTART_LO: if (hi_r) lst_r[v_r] <= {lst_c[31:16], d_r, lst_c[7:0]};
          REG_LEND_HI:
            if (hi_r) lend_r[v_r] <= {d_r, lend_c[23:0]};
            else lend_r[v_r] <= {lend_c[31:24], d_r, lend_c[15:0]};
          REG_LEND_LO: if (hi_r) lend_r[v_r] <= {lend_c[31:16], d_r, lend_c[7:0]};
          REG_LVL_RATE: if (hi_r) lrate_r[v_r] <= d_r;
          REG_LVL_START: if (!hi_r) lsta_r[v_r] <= {6'd0, d_r, 18'd0};
          REG_LVL_END: if (!hi_r) lendv_r[v_r] <= {6'd0, d_r, 18'd0};
          REG_LVL_RAW:
            if (hi_r) begin
              lraw_r[v_r] <= {d_r, lraw_c[7:0]};
              lpos_r[v_r] <= {6'd0, d_r, lraw_c[7:0], 10'd0};
            end else begin
              lraw_r[v_r] <= {lraw_c[15:8], d_r};
              lpos_r[v_r] <= {6'd0, lraw_c[15:8], d_r, 10'd0};
            end
          REG_POS_HI:
            if (hi_r) wpos_r[v_r] <= {d_r, wpos_c[23:0]};
            else wpos_r[v_r] <= {wpos_c[31:24], d_r, wpos_c[15:0]};
          REG_POS_LO:
            if (hi_r) wpos_r[v_r] <= {wpos_c[31:16], d_r, wpos_c[7:0]};
            else wpos_r[v_r] <= {wpos_c[31:8], d_r & 8'hF8};
          REG_LVL_CTRL: if (hi_r) lflg_r[v_r] <= {lflg_c[7], d_r[6:0]};
          REG_LAST_VOICE: if (hi_r) last_r <= d_r[4:0];
          REG_CONTROL:
            if (hi_r) begin
              ctl_r[v_r] <= d_r;
              if (d_r == CtrlKeyOn) begin
                key_r[v_r] <= 1'b1; ramp_r[v_r] <= RampFull;
              end else if (d_r == CtrlKeyOff && mode_r == 8'd0) begin
                wflg_r[v_r] <= wflg_c | FlagStop;
                lflg_r[v_r] <= lflg_c | LflagStop;
                key_r[v_r] <= 1'b0;
              end
            end
          REG_BANK: if (hi_r) bank_r[v_r] <= d_r;
          REG_MODE: if (hi_r) mode_r <= d_r;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/wavetable_voice_engine_unit.sv =====
// a tick's result is registered in the compute state and is on the ports during
//   write-back; a write gives no result
// a tick goes idle, read, compute, write-back and a write skips compute; a new item
//   is taken only in idle, after the read-modify-write of the voice table
// reset: synchronous active-low rst_n stops all voices, clears the state table
//   and restores the configuration defaults; the receiver cannot stall results
module wavetable_voice_engine_unit
  import wve_pkg::*;
#(
  parameter int unsigned VOICE_COUNT   = 32,
  parameter int unsigned ROM_ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [4:0]  in_voice_index,
  input  logic [4:0]  in_reg_index,
  input  logic        in_high_byte,
  input  logic [7:0]  in_data_byte,
  // result channel, one cycle strobe
  output logic        out_valid,
  output logic [23:0] out_fetch_address,
  output logic [23:0] out_next_address,
  output logic [8:0]  out_fraction,
  output logic        out_ulaw_format,
  output logic        out_byte_format,
  output logic [14:0] out_gain,
  output logic        out_audible,
  output logic        out_wave_irq,
  output logic        out_envelope_irq
);

  wve_cmd_t    cmd;
  wve_status_t status;

  // sequencer: idle, read voice, compute, write back
  wve_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // voice table plus oscillator, envelope and ramp arithmetic
  wve_datapath #(
    .VOICE_COUNT   (VOICE_COUNT),
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_voice_index    (in_voice_index),
    .in_reg_index      (in_reg_index),
    .in_high_byte      (in_high_byte),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_fetch_address (out_fetch_address),
    .out_next_address  (out_next_address),
    .out_fraction      (out_fraction),
    .out_ulaw_format   (out_ulaw_format),
    .out_byte_format   (out_byte_format),
    .out_gain          (out_gain),
    .out_audible       (out_audible),
    .out_wave_irq      (out_wave_irq),
    .out_envelope_irq  (out_envelope_irq)
  );

endmodule

// ===== rtl/wve_checker.sv =====
`include "wavetable_voice_engine_unit_assert.svh"
module wve_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted item makes the block busy
  `WVE_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
  // a result only comes while busy
  `WVE_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy, "result while idle")
  // results are single-cycle strobes
  `WVE_ASSERT_NXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid, "double result")

endmodule

bind wavetable_voice_engine_unit wve_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
